[design/mxt_pkg.sv]
`default_nettype none

package mxt_pkg;

    localparam int WORD_BITS = 32;
    localparam int MAX_ITEMS = 1024;
    // root plus one full path per item
    localparam int NODES     = MAX_ITEMS * WORD_BITS + 1;
    localparam int ID_BITS   = $clog2(NODES);
    // node 0 (root) lives in flops; memory holds nodes 1..NODES-1 at id-1
    localparam int ADDR_BITS = $clog2(NODES - 1);
    localparam int MEM_DEPTH = NODES - 1;
    localparam int LVL_BITS  = $clog2(WORD_BITS);
    localparam int MISS_BITS = $clog2(WORD_BITS + 1);

    typedef logic [ID_BITS-1:0]   node_id_t;
    typedef logic [ADDR_BITS-1:0] mem_addr_t;
    typedef logic [LVL_BITS-1:0]  lvl_t;
    typedef logic [MISS_BITS-1:0] miss_t;
    typedef logic [WORD_BITS-1:0] word_t;

    // child links indexed by branch bit; 0 = absent
    typedef logic [1:0][ID_BITS-1:0] entry_t;

    typedef struct packed {
        logic load;     // parallel load of prefix bits, clears result bits
        logic shift;    // advance one level
        logic acc_bit;  // result bit entering at the low end
    } mxt_chain_ctl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_WALK,
        ST_DECIDE,
        ST_WPAR,
        ST_WNEW,
        ST_FIN
    } mxt_state_t;

endpackage

`default_nettype wire

[design/max_xor_subarray_trie_unit.sv]
`default_nettype none

// Maximum XOR of a contiguous subarray, using a binary trie of prefixes.
// Input stream s_*: tdata = word, tuser = start flag (begins a new array).
// Output stream s_* -> m_*: tdata = best XOR so far, tuser = overflow.
// One result transaction per input transaction, in order.
// Per word: a load step, then a walk (query and insert lookup share the
// walk, one trie level per cycle on the two read ports of the node memory),
// a decide step, then a parent write and one write per new node when new
// nodes are needed, and a hand-off of the result. A start word first
// inserts the zero prefix. One word is in flight at a time.
// The walk bits and the result bits move through a row of 32 bit cells.
// Reset empties the trie (root only), clears prefix and best; no memory
// clearing pass: a fill count tracks the allocated nodes and every new node
// is written when it is allocated. The output register holds a result while
// m_tready is low; the next word is taken meanwhile, and its result waits
// until the output register is free.
module max_xor_subarray_trie_unit
    import mxt_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] word
    input  wire logic        s_tuser,   // [0] start_req
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [31:0] best
    output logic             m_tuser    // [0] overflow
);

    // control state
    mxt_state_t state_reg, state_next;
    node_id_t   nodes_used_reg, nodes_used_next;
    entry_t     root_reg, root_next;
    word_t      prefix_reg, prefix_next;
    word_t      best_reg, best_next;
    logic       first_reg, first_next;
    logic       out_valid_reg, out_valid_next;

    // payload
    word_t      word_reg, word_next;
    node_id_t   q_cur_reg, q_cur_next;
    node_id_t   f_cur_reg, f_cur_next;
    logic       q_alive_reg, q_alive_next;
    logic       f_alive_reg, f_alive_next;
    miss_t      miss_reg, miss_next;
    lvl_t       lvl_reg, lvl_next;
    entry_t     f_entry_reg, f_entry_next;
    logic       ovf_reg, ovf_next;
    word_t      out_best_reg, out_best_next;
    logic       out_ovf_reg, out_ovf_next;

    // node memory: two read ports (query walk, insert walk), one write port
    entry_t     mem [MEM_DEPTH];
    entry_t     q_rd_reg;
    entry_t     f_rd_reg;
    logic       mem_we;
    mem_addr_t  mem_waddr;
    entry_t     mem_wdata;
    mem_addr_t  q_raddr;
    mem_addr_t  f_raddr;

    mxt_chain_ctl_t chain_ctl;
    word_t          chain_load;
    logic           head_bit;
    word_t          acc;

    entry_t     q_ent;
    entry_t     f_ent;
    entry_t     new_ent;
    node_id_t   free_nodes;
    logic       wbit;
    lvl_t       miss_lvl;

    mxt_chain u_chain (
        .clk      (clk),
        .ctl      (chain_ctl),
        .load_val (chain_load),
        .head_bit (head_bit),
        .acc      (acc)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_best_reg;
    assign m_tuser  = out_ovf_reg;

    assign q_ent      = (q_cur_reg == '0) ? root_reg : q_rd_reg;
    assign f_ent      = (f_cur_reg == '0) ? root_reg : f_rd_reg;
    assign free_nodes = ID_BITS'(NODES) - nodes_used_reg;
    assign miss_lvl   = LVL_BITS'(miss_reg - 1'b1);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = s_tuser ? ST_WPAR : ST_LOAD;
                end
            end
            ST_LOAD:   state_next = ST_WALK;
            ST_WALK:
            begin
                if (lvl_reg == '0)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (miss_reg == '0 || (ID_BITS'(miss_reg) > free_nodes))
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    state_next = ST_WPAR;
                end
            end
            ST_WPAR:   state_next = ST_WNEW;
            ST_WNEW:
            begin
                if (lvl_reg == '0)
                begin
                    state_next = first_reg ? ST_LOAD : ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        nodes_used_next = nodes_used_reg;
        root_next       = root_reg;
        prefix_next     = prefix_reg;
        best_next       = best_reg;
        first_next      = first_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        word_next       = word_reg;
        q_cur_next      = q_cur_reg;
        f_cur_next      = f_cur_reg;
        q_alive_next    = q_alive_reg;
        f_alive_next    = f_alive_reg;
        miss_next       = miss_reg;
        lvl_next        = lvl_reg;
        f_entry_next    = f_entry_reg;
        ovf_next        = ovf_reg;
        out_best_next   = out_best_reg;
        out_ovf_next    = out_ovf_reg;
        mem_we          = 1'b0;
        mem_waddr       = mem_addr_t'(f_cur_reg - 1'b1);
        mem_wdata       = f_entry_reg;
        chain_ctl       = '0;
        chain_load      = prefix_reg ^ word_reg;
        wbit            = prefix_reg[miss_lvl];
        new_ent         = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    word_next  = s_tdata;
                    first_next = s_tuser;
                    if (s_tuser)
                    begin
                        // new array: empty trie, then insert the zero prefix
                        prefix_next     = '0;
                        best_next       = '0;
                        nodes_used_next = ID_BITS'(1);
                        root_next       = '0;
                        f_cur_next      = '0;
                        f_entry_next    = '0;
                        miss_next       = MISS_BITS'(WORD_BITS);
                    end
                end
            end
            ST_LOAD:
            begin
                prefix_next   = prefix_reg ^ word_reg;
                chain_ctl.load = 1'b1;
                q_cur_next    = '0;
                f_cur_next    = '0;
                q_alive_next  = 1'b1;
                f_alive_next  = 1'b1;
                miss_next     = '0;
                first_next    = 1'b0;
                lvl_next      = LVL_BITS'(WORD_BITS - 1);
            end
            ST_WALK:
            begin
                chain_ctl.shift = 1'b1;
                // query: prefer the opposite bit
                if (q_alive_reg)
                begin
                    if (q_ent[!head_bit] != '0)
                    begin
                        q_cur_next        = q_ent[!head_bit];
                        chain_ctl.acc_bit = 1'b1;
                    end
                    else if (q_ent[head_bit] != '0)
                    begin
                        q_cur_next = q_ent[head_bit];
                    end
                    else
                    begin
                        q_alive_next = 1'b0;
                    end
                end
                // insert lookup: follow own bit until the path ends
                if (f_alive_reg)
                begin
                    if (f_ent[head_bit] != '0)
                    begin
                        f_cur_next = f_ent[head_bit];
                    end
                    else
                    begin
                        f_alive_next = 1'b0;
                        f_entry_next = f_ent;
                        miss_next    = MISS_BITS'(lvl_reg) + 1'b1;
                    end
                end
                lvl_next = lvl_reg - 1'b1;
            end
            ST_DECIDE:
            begin
                if (acc > best_reg)
                begin
                    best_next = acc;
                end
                ovf_next = (ID_BITS'(miss_reg) > free_nodes);
            end
            ST_WPAR:
            begin
                // hook the first new node under the last existing one
                if (f_cur_reg == '0)
                begin
                    root_next[wbit] = nodes_used_reg;
                end
                else
                begin
                    mem_we          = 1'b1;
                    mem_wdata       = f_entry_reg;
                    mem_wdata[wbit] = nodes_used_reg;
                end
                lvl_next = miss_lvl;
            end
            ST_WNEW:
            begin
                if (lvl_reg != '0)
                begin
                    new_ent[prefix_reg[lvl_reg - 1'b1]] = nodes_used_reg + 1'b1;
                end
                mem_we          = 1'b1;
                mem_waddr       = mem_addr_t'(nodes_used_reg - 1'b1);
                mem_wdata       = new_ent;
                nodes_used_next = nodes_used_reg + 1'b1;
                lvl_next        = lvl_reg - 1'b1;
            end
            ST_FIN:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_best_next  = best_reg;
                    out_ovf_next   = ovf_reg;
                end
            end
            default:
            begin
            end
        endcase

        q_raddr = mem_addr_t'(q_cur_next - 1'b1);
        f_raddr = mem_addr_t'(f_cur_next - 1'b1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            nodes_used_reg <= ID_BITS'(1);
            root_reg       <= '0;
            prefix_reg     <= '0;
            best_reg       <= '0;
            first_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            nodes_used_reg <= nodes_used_next;
            root_reg       <= root_next;
            prefix_reg     <= prefix_next;
            best_reg       <= best_next;
            first_reg      <= first_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg     <= word_next;
        q_cur_reg    <= q_cur_next;
        f_cur_reg    <= f_cur_next;
        q_alive_reg  <= q_alive_next;
        f_alive_reg  <= f_alive_next;
        miss_reg     <= miss_next;
        lvl_reg      <= lvl_next;
        f_entry_reg  <= f_entry_next;
        ovf_reg      <= ovf_next;
        out_best_reg <= out_best_next;
        out_ovf_reg  <= out_ovf_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        q_rd_reg <= mem[q_raddr];
        f_rd_reg <= mem[f_raddr];
    end

    // checks
    a_nodes_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (nodes_used_reg != '0) && (nodes_used_reg <= ID_BITS'(NODES)))
        else $error("node count out of range");

    a_walk_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK && lvl_reg != '0) |=>
            (state_reg == ST_WALK && lvl_reg == $past(lvl_reg) - 1'b1))
        else $error("walk level did not advance");

    a_alloc: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WNEW) |=> (nodes_used_reg == $past(nodes_used_reg) + 1'b1))
        else $error("node not allocated on write");

    a_best_mono: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DECIDE) |=> (best_reg >= $past(best_reg)))
        else $error("best decreased within an array");

    a_no_write_on_ovf: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DECIDE && (ID_BITS'(miss_reg) > free_nodes)) |=>
            (state_reg == ST_FIN && ovf_reg))
        else $error("insert attempted on full store");

endmodule

`default_nettype wire

[design/mxt_cell.sv]
`default_nettype none

module mxt_cell
    import mxt_pkg::*;
(
    input  wire logic           clk,
    input  wire mxt_chain_ctl_t ctl,
    input  wire logic           load_bit,
    input  wire logic           q_in,
    input  wire logic           a_in,
    output logic                q,
    output logic                a
);

    logic q_reg, q_next;
    logic a_reg, a_next;

    always_comb
    begin
        q_next = q_reg;
        a_next = a_reg;
        if (ctl.load)
        begin
            q_next = load_bit;
            a_next = 1'b0;
        end
        else if (ctl.shift)
        begin
            q_next = q_in;
            a_next = a_in;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        a_reg <= a_next;
    end

    assign q = q_reg;
    assign a = a_reg;

endmodule

`default_nettype wire

[design/mxt_chain.sv]
`default_nettype none

module mxt_chain
    import mxt_pkg::*;
(
    input  wire logic           clk,
    input  wire mxt_chain_ctl_t ctl,
    input  wire word_t          load_val,
    output logic                head_bit,   // prefix bit of the current level
    output word_t               acc         // result word, MSB first in
);

    word_t q_bits;
    word_t a_bits;

    for (genvar k = 0; k < WORD_BITS; k++)
    begin : g_cell
        logic q_in;
        logic a_in;
        if (k == 0)
        begin : g_tail
            assign q_in = 1'b0;
            assign a_in = ctl.acc_bit;
        end
        else
        begin : g_link
            assign q_in = q_bits[k-1];
            assign a_in = a_bits[k-1];
        end
        mxt_cell u_cell (
            .clk      (clk),
            .ctl      (ctl),
            .load_bit (load_val[k]),
            .q_in     (q_in),
            .a_in     (a_in),
            .q        (q_bits[k]),
            .a        (a_bits[k])
        );
    end

    assign head_bit = q_bits[WORD_BITS-1];
    assign acc      = a_bits;

endmodule

`default_nettype wire

[sim/tb_top.sv]
`default_nettype none

// Checks max_xor_subarray_trie_unit against a trie model kept in the bench.
// Every accepted input transaction is run through the model right away. The
// predicted best value and overflow flag are queued, and each output
// transaction is compared with the oldest queued entry.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mxt_pkg::*;

    typedef struct packed {
        word_t best;
        logic  ovf;
    } result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;      // [31:0] word
    logic        s_tuser = 1'b0;    // [0] start_req
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;           // [31:0] best
    logic        m_tuser;           // [0] overflow

    // Trie model: two child links per node, 0 = absent; node 0 is the root.
    int unsigned trie_link [NODES][2];
    int unsigned nodes_taken = 1;
    word_t       run_prefix = '0;
    word_t       best_xor = '0;
    result_t     last_result;

    // Expected output transactions, oldest first.
    result_t     pending_best [$];
    result_t     got_exp;
    int          bad_cnt = 0;

    // Idle controls for the sender and the receiver.
    bit          src_idle = 1'b0;
    bit          sink_idle = 1'b0;
    int          hold_left = 0;     // long receiver hold-off, in cycles
    int          stall_left = 0;

    max_xor_subarray_trie_unit u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #6 clk = ~clk;

    // ------------------------------------------------------------------
    // Trie model
    // ------------------------------------------------------------------

    // Insert v only if all the nodes its path lacks are still free.
    function automatic bit trie_add(input word_t v);
        int unsigned cur;
        int unsigned need;
        int          b;
        bit          br;
        cur = 0;
        need = 0;
        for (b = WORD_BITS - 1; b >= 0; b--)
        begin
            br = v[b];
            if (trie_link[cur][br] != 0)
                cur = trie_link[cur][br];
            else
            begin
                need = b + 1;
                break;
            end
        end
        if (need > NODES - nodes_taken)
            return 1'b0;
        for (b = int'(need) - 1; b >= 0; b--)
        begin
            br = v[b];
            trie_link[cur][br] = nodes_taken;
            cur = nodes_taken;
            nodes_taken++;
        end
        return 1'b1;
    endfunction

    // Greedy walk toward the opposite bit; 0 when the trie is empty.
    function automatic bit trie_widest_xor(input word_t v, output word_t acc);
        int unsigned cur;
        int          b;
        bit          br;
        cur = 0;
        acc = '0;
        if (trie_link[0][0] == 0 && trie_link[0][1] == 0)
            return 1'b0;
        for (b = WORD_BITS - 1; b >= 0; b--)
        begin
            br = v[b];
            if (trie_link[cur][!br] != 0)
            begin
                cur = trie_link[cur][!br];
                acc[b] = 1'b1;
            end
            else if (trie_link[cur][br] != 0)
                cur = trie_link[cur][br];
            else
                break;
        end
        return 1'b1;
    endfunction

    function automatic result_t step_prefix(input word_t w, input bit new_arr);
        result_t r;
        word_t   cand;
        bit      ok;
        if (new_arr)
        begin
            // only allocated nodes can hold links
            for (int i = 0; i < int'(nodes_taken); i++)
            begin
                trie_link[i][0] = 0;
                trie_link[i][1] = 0;
            end
            nodes_taken = 1;
            run_prefix = '0;
            best_xor = '0;
            ok = trie_add('0);
        end
        run_prefix = run_prefix ^ w;
        if (trie_widest_xor(run_prefix, cand) && cand > best_xor)
            best_xor = cand;
        ok = trie_add(run_prefix);
        r.best = best_xor;
        r.ovf = !ok;
        last_result = r;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Handshake helpers
    // ------------------------------------------------------------------

    // Mostly back-to-back, some short gaps, a few long ones.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 12);
        else
            return $urandom_range(30, 80);
    endfunction

    // Offer one word; predict its result at the accepting edge.
    // Entered and left at a falling edge.
    task automatic send_word(input word_t w, input bit new_arr);
        int gap;
        gap = src_idle ? pick_gap() : 0;
        if (gap > 0)
        begin
            s_tvalid = 1'b0;
            s_tdata = $urandom;
            s_tuser = $urandom_range(0, 1);
            repeat (gap) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata = w;
        s_tuser = new_arr;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_best = {pending_best, step_prefix(w, new_arr)};
        @(negedge clk);
    endtask

    // Sender stays quiet until every predicted result has come out.
    task automatic wait_drained();
        s_tvalid = 1'b0;
        while (pending_best.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Receiver: random stalls when enabled, plus the long hold-off request.
    initial
    begin : sink
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                m_tready = 1'b0;
                hold_left--;
            end
            else if (stall_left > 0)
            begin
                m_tready = 1'b0;
                stall_left--;
            end
            else
            begin
                m_tready = 1'b1;
                if (sink_idle && $urandom_range(0, 3) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    // Result checker: compare each output transaction with the oldest entry.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_best.size() == 0)
            begin
                if (bad_cnt < 10)
                    $display("%0t: unexpected result best=%h overflow=%b",
                             $realtime, m_tdata, m_tuser);
                bad_cnt++;
            end
            else
            begin
                got_exp = pending_best.pop_front();
                if (m_tdata !== got_exp.best || m_tuser !== got_exp.ovf)
                begin
                    if (bad_cnt < 10)
                        $display("%0t: best exp %h got %h, overflow exp %b got %b",
                                 $realtime, got_exp.best, m_tdata, got_exp.ovf, m_tuser);
                    bad_cnt++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // No start after reset: first query sees an empty trie and gives best 0.
    task automatic test_cold_start();
        src_idle = 1'b0;
        sink_idle = 1'b0;
        send_word(32'h0000_0005, 1'b0);
        send_word(32'h0000_0003, 1'b0);
        send_word(32'h0000_0000, 1'b0);
        send_word(32'hFFFF_FFFF, 1'b0);
    endtask

    // Field extremes, already-stored prefixes, back-to-back starts.
    task automatic test_extremes();
        send_word(32'h0000_0000, 1'b1);
        send_word(32'hFFFF_FFFF, 1'b1);
        send_word(32'hFFFF_FFFF, 1'b0);   // prefix back to 0, no new node
        send_word(32'h8000_0000, 1'b1);
        send_word(32'h0000_0001, 1'b0);
        send_word(32'h7FFF_FFFF, 1'b0);
        send_word(32'hAAAA_AAAA, 1'b1);
        send_word(32'h5555_5555, 1'b0);
        send_word(32'hAAAA_AAAA, 1'b0);
        send_word(32'h0000_0001, 1'b1);
        send_word(32'h0000_0001, 1'b1);
        send_word(32'hDEAD_BEEF, 1'b1);
        send_word(32'h0000_0000, 1'b0);
        send_word(32'h0000_0000, 1'b0);
        send_word(32'hFFFF_FFFF, 1'b0);
        wait_drained();
    endtask

    // Receiver holds off long enough for the block to stall its input.
    task automatic test_backpressure();
        src_idle = 1'b0;
        sink_idle = 1'b0;
        hold_left = 400;
        send_word($urandom, 1'b1);
        for (int k = 0; k < 9; k++)
            send_word($urandom, 1'b0);
        wait_drained();
    endtask

    // Arrays of random length and content; now and then an array continues
    // without a start.
    task automatic test_random_arrays(input int n_items);
        int    sent;
        int    len;
        word_t w;
        sent = 0;
        while (sent < n_items)
        begin
            len = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                              : $urandom_range(1, 12);
            src_idle = ($urandom_range(0, 3) != 0);
            sink_idle = ($urandom_range(0, 3) != 0);
            for (int k = 0; k < len; k++)
            begin
                case ($urandom_range(0, 7))
                    0: w = '0;
                    1: w = '1;
                    2: w = word_t'(1) << $urandom_range(0, WORD_BITS - 1);
                    3: w = $urandom_range(0, 15);
                    4: w = ~(word_t'(1) << $urandom_range(0, WORD_BITS - 1));
                    default: w = $urandom;
                endcase
                send_word(w, k == 0 && $urandom_range(0, 7) != 0);
                sent++;
            end
        end
    endtask

    // One long array whose prefixes spread over the top ten bits (bit-reversed
    // count), so each new prefix needs many nodes and the store runs full. Stored
    // prefixes are revisited now and then: those must always go in.
    task automatic test_store_full();
        word_t      target;
        word_t      seen [$];
        logic [9:0] rev;
        int         drops;
        int         i;
        src_idle = 1'b1;
        sink_idle = 1'b1;
        drops = 0;
        send_word($urandom, 1'b1);
        seen = {seen, run_prefix};
        for (i = 0; drops < 40 && i < 1700; i++)
        begin
            if ($urandom_range(0, drops > 0 ? 2 : 9) == 0)
                target = seen[$urandom_range(0, seen.size() - 1)];
            else
            begin
                for (int b = 0; b < 10; b++)
                    rev[b] = i[9 - b];
                target = $urandom;
                target[31:22] = rev;
            end
            send_word(target ^ run_prefix, 1'b0);
            if (last_result.ovf)
                drops++;
            else
                seen = {seen, target};
        end
        // a fresh array must work normally again
        send_word($urandom, 1'b1);
        send_word($urandom, 1'b0);
        send_word($urandom, 1'b0);
    endtask

    task automatic finish_run();
        wait_drained();
        // let any straggler show up
        repeat (120) @(posedge clk);
        if (bad_cnt == 0 && pending_best.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    endtask

    initial
    begin
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_cold_start();
        test_extremes();
        test_backpressure();
        test_random_arrays(120);
        test_store_full();
        finish_run();
    end

    // Watchdog: well beyond the slowest legal run.
    initial
    begin
        #20_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire
